@@ rtl/lasu_pkg.sv @@
// Shared types and constants for the life automaton stencil unit.
package lasu_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int DIM_W      = 12;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
  localparam int POS_W      = 2 * DIM_W;
  localparam int CELL_W     = 8;
  localparam int LEVEL_W    = 8;
  localparam int COUNT_W    = 4;
  localparam int WIN_CELLS  = 9;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [CELL_W-1:0]  CELL_MAX    = 8'd255;
  localparam logic [COUNT_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [COUNT_W-1:0] SURVIVE_MAX = 4'd3;
  localparam logic [COUNT_W-1:0] BIRTH_COUNT = 4'd3;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 12'd1920;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 12'd1080;
  localparam logic [LEVEL_W-1:0] LEVELS_RST = 8'd1;
  localparam logic [COUNT_W-1:0] ACC_RST    = 4'd5;

  localparam logic [3:0]         CALC_LEN   = 4'd9;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LIFE_LEVELS  = 3'd2,
    REG_ACC_ENABLE   = 3'd3,
    REG_ACC_COUNT    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic              flush;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] next_value;
    logic              frame_end;
  } out_item_t;

  typedef logic [WIN_CELLS-1:0][CELL_W-1:0] cell_window_t;

  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
  } nbr_mask_t;

  typedef struct packed {
    logic [CELL_W-1:0]  step;
    logic               acc_enable;
    logic [COUNT_W-1:0] acc_count;
  } rule_cfg_t;

endpackage

@@ rtl/lasu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lasu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lasu_rule.sv @@
// Neighbour count over the 3x3 window and the multi-level life update rule.
module lasu_rule import lasu_pkg::*; (
  input  cell_window_t      win,
  input  nbr_mask_t         mask,
  input  rule_cfg_t         cfg,
  output logic [CELL_W-1:0] next_value
);

  logic [WIN_CELLS-1:0] live;
  logic [WIN_CELLS-1:0] en;
  logic [COUNT_W-1:0]   n;
  logic [CELL_W-1:0]    centre;
  logic [CELL_W:0]      sum;

  always_comb begin
    for (int i = 0; i < WIN_CELLS; i++) begin
      live[i] = win[i] != '0;
    end
    // window index = column * 3 + row
    en[0] = mask.left & mask.up;
    en[1] = mask.left;
    en[2] = mask.left & mask.down;
    en[3] = mask.up;
    en[4] = 1'b0;
    en[5] = mask.down;
    en[6] = mask.right & mask.up;
    en[7] = mask.right;
    en[8] = mask.right & mask.down;
    n = COUNT_W'($countones(live & en));
  end

  always_comb begin
    centre = win[4];
    sum    = {1'b0, centre} + {1'b0, cfg.step};
    if (centre != '0) begin
      if (cfg.acc_enable && n == cfg.acc_count) begin
        next_value = sum[CELL_W] ? CELL_MAX : sum[CELL_W-1:0];
      end else if (!(n inside {[SURVIVE_MIN:SURVIVE_MAX]})) begin
        next_value = (centre > cfg.step) ? centre - cfg.step : '0;
      end else begin
        next_value = centre;
      end
    end else begin
      next_value = (n == BIRTH_COUNT) ? cfg.step : '0;
    end
  end

endmodule

@@ rtl/life_automaton_stencil_unit.sv @@
// Top level: streaming multi-level life stencil with two line-store RAMs.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | request   | in_valid/in_ready  | in_data  (cell_value, flush)
//  out     | result    | out_valid/out_ready| out_data (next_value, frame_end)
//  apb     | config    | psel/penable/pready| paddr, pwdata, prdata
//
// One cell per cycle when not busy and the output is not stalled; results trail
// the input by one frame line plus one cell. Each cell reads both line stores in
// the accept cycle and writes them back as it leaves the read stage; a same-column
// write in flight is forwarded to the new read. After reset a clearing pass zeroes
// the line stores with in_ready low. Every register write holds in_ready low while
// the row base and frame size are rescaled and step = 255/levels is then divided out one bit per cycle.
// A stalled output holds the result register, then the read stage, then input.
module life_automaton_stencil_unit import lasu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [LEVEL_W-1:0] life_levels;
  logic               accumulate_enable;
  logic [COUNT_W-1:0] accumulate_count;

  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [LEVEL_W-1:0] lv_eff;
  reg_index_t         reg_sel;
  logic               cfg_write;

  logic [3:0]         calc_cnt;
  logic [CELL_W-1:0]  step;
  logic [LEVEL_W-1:0] rem;
  logic [LEVEL_W:0]   rem_trial;
  logic               clearing;
  logic [COL_W-1:0]   clr_addr;
  logic               busy;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic [POS_W-1:0]   row_base;
  logic [POS_W-1:0]   frame_total;
  logic [POS_W-1:0]   pos;
  logic               emit;
  logic               last;
  logic               col_wrap;
  logic               in_fire;
  logic [CELL_W-1:0]  in_cell;

  logic               s1_valid;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  logic [CELL_W-1:0]  s1_value;
  logic               s1_emit;
  logic               s1_last;
  logic               s1_fwd;
  logic [CELL_W-1:0]  s1_fwd_top;
  logic [CELL_W-1:0]  s1_fwd_mid;
  logic               s1_fire;
  logic               out_free;

  logic               ram_we;
  logic [COL_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]  upper_wdata;
  logic [CELL_W-1:0]  middle_wdata;
  logic [CELL_W-1:0]  upper_rdata;
  logic [CELL_W-1:0]  middle_rdata;
  logic [CELL_W-1:0]  top_cur;
  logic [CELL_W-1:0]  mid_cur;

  cell_window_t       win;
  cell_window_t       win_next;
  logic [ROW_W-1:0]   cen_row;
  logic [DIM_W-1:0]   cen_col;
  nbr_mask_t          mask;
  rule_cfg_t          rule_cfg;
  logic [CELL_W-1:0]  rule_value;

  // configuration port
  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= WIDTH_RST;
      frame_height      <= HEIGHT_RST;
      life_levels       <= LEVELS_RST;
      accumulate_enable <= 1'b0;
      accumulate_count  <= ACC_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_FRAME_WIDTH:  frame_width       <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height      <= pwdata[DIM_W-1:0];
        REG_LIFE_LEVELS:  life_levels       <= pwdata[LEVEL_W-1:0];
        REG_ACC_ENABLE:   accumulate_enable <= pwdata[0];
        REG_ACC_COUNT:    accumulate_count  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      REG_LIFE_LEVELS:  prdata = DATA_W'(life_levels);
      REG_ACC_ENABLE:   prdata = DATA_W'(accumulate_enable);
      REG_ACC_COUNT:    prdata = DATA_W'(accumulate_count);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    lv_eff = (life_levels == '0) ? LEVEL_W'(1) : life_levels;
  end

  // derived values: rescale, then restoring divide 255 / levels
  assign rem_trial = {rem, 1'b1};

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      calc_cnt <= CALC_LEN;
    end else if (calc_cnt != '0) begin
      calc_cnt <= calc_cnt - 4'd1;
      if (calc_cnt == CALC_LEN) begin
        row_base    <= POS_W'(row) * POS_W'(w_eff);
        frame_total <= POS_W'(w_eff) * POS_W'({1'b0, h_eff} + 13'd1);
        rem         <= '0;
      end else if (rem_trial >= {1'b0, lv_eff}) begin
        rem  <= LEVEL_W'(rem_trial - {1'b0, lv_eff});
        step <= {step[CELL_W-2:0], 1'b1};
      end else begin
        rem  <= rem_trial[LEVEL_W-1:0];
        step <= {step[CELL_W-2:0], 1'b0};
      end
    end else if (in_fire) begin
      if (last) begin
        row_base <= '0;
      end else if (col_wrap) begin
        row_base <= row_base + POS_W'(w_eff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + COL_W'(1);
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  assign busy = clearing || (calc_cnt != '0);

  // input position tracking
  assign pos      = row_base + POS_W'(col);
  assign emit     = pos > POS_W'(w_eff);
  assign last     = emit && (pos >= frame_total);
  assign col_wrap = ({1'b0, col} + 12'd1) >= w_eff;
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && (!s1_emit || out_free);
  assign in_ready = !busy && (!s1_valid || s1_fire);
  assign in_fire  = in_valid && in_ready;
  assign in_cell  = in_data.flush ? '0 : in_data.cell_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (last) begin
        col <= '0;
        row <= '0;
      end else if (col_wrap) begin
        col <= '0;
        row <= row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_col     <= col;
      s1_row     <= row;
      s1_value   <= in_cell;
      s1_emit    <= emit;
      s1_last    <= last;
      s1_fwd     <= s1_fire && (s1_col == col);
      s1_fwd_top <= mid_cur;
      s1_fwd_mid <= s1_value;
    end
  end

  assign top_cur      = s1_fwd ? s1_fwd_top : upper_rdata;
  assign mid_cur      = s1_fwd ? s1_fwd_mid : middle_rdata;
  assign ram_we       = clearing || s1_fire;
  assign ram_waddr    = clearing ? clr_addr : s1_col;
  assign upper_wdata  = clearing ? '0 : mid_cur;
  assign middle_wdata = clearing ? '0 : s1_value;

  lasu_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (upper_wdata),
    .re    (in_fire),
    .raddr (col),
    .rdata (upper_rdata)
  );

  lasu_ram #(.WIDTH(CELL_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (middle_wdata),
    .re    (in_fire),
    .raddr (col),
    .rdata (middle_rdata)
  );

  // window and border masks
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_next[i] = win[i+3];
    end
    win_next[6] = top_cur;
    win_next[7] = mid_cur;
    win_next[8] = s1_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_fire) begin
      win <= win_next;
    end
  end

  always_comb begin
    if (s1_col == '0) begin
      cen_row = (s1_row >= ROW_W'(2)) ? s1_row - ROW_W'(2) : '0;
      cen_col = w_eff - 12'd1;
    end else begin
      cen_row = (s1_row >= ROW_W'(1)) ? s1_row - ROW_W'(1) : '0;
      cen_col = {1'b0, s1_col} - 12'd1;
    end
    mask.left  = cen_col != '0;
    mask.right = (cen_col + 12'd1) < w_eff;
    mask.up    = cen_row != '0;
    mask.down  = (cen_row + ROW_W'(1)) < ROW_W'(h_eff);
  end

  assign rule_cfg.step       = step;
  assign rule_cfg.acc_enable = accumulate_enable;
  assign rule_cfg.acc_count  = accumulate_count;

  lasu_rule u_rule (
    .win        (win_next),
    .mask       (mask),
    .cfg        (rule_cfg),
    .next_value (rule_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_data.next_value <= rule_value;
      out_data.frame_end  <= s1_last;
    end
  end

endmodule

@@ rtl/lasu_checker.sv @@
// Port-level assertions for the stencil unit, bound to the top level.
module lasu_checker import lasu_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input out_item_t         out_data,
  input logic              psel,
  input logic              penable,
  input logic              pwrite
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // clearing pass blocks input after reset
  a_reset_block: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

  // derived values recompute after each register write
  a_cfg_block: assert property (@(posedge clk)
    psel && penable && pwrite |=> !in_ready)
    else $error("input taken while derived values recompute");

endmodule

bind life_automaton_stencil_unit lasu_checker u_lasu_checker (.*);
